// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the touch press classifier RTL.
// Included by the modules that carry concurrent checks; needs no package.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define TPC_ASSERT_IMP(LBL, CLK, RSTN, ANTE, CONS) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error("touch press classifier check failed");

// Next-cycle implication, disabled while reset is active.
`define TPC_ASSERT_NXT(LBL, CLK, RSTN, ANTE, CONS) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error("touch press classifier check failed");

`endif

// ===== hdl/tpc_pkg.sv =====
// Package for the touch press classifier: field codes, reset values and types.
// No dependencies; imported by the classifier, emitter, top level and testbench.
`default_nettype none

package tpc_pkg;

    // Input kind codes
    localparam logic [1:0] KIND_POLL   = 2'd0;
    localparam logic [1:0] KIND_SINGLE = 2'd1;
    localparam logic [1:0] KIND_MULTI  = 2'd2;

    // Action codes
    localparam logic [2:0] ACT_DOWN  = 3'd0;
    localparam logic [2:0] ACT_MOVE  = 3'd1;
    localparam logic [2:0] ACT_UP    = 3'd2;
    localparam logic [2:0] ACT_HOVER = 3'd3;

    // Result event codes
    localparam logic [1:0] EV_MOVE    = 2'd0;
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;

    // Button codes and mask bits
    localparam logic BTN_LEFT  = 1'b0;
    localparam logic BTN_RIGHT = 1'b1;

    // Configuration register indexes and reset values
    localparam logic        REG_LONG_PRESS = 1'b0;
    localparam logic        REG_SLOP       = 1'b1;
    localparam logic [15:0] LONG_PRESS_RST = 16'd500;
    localparam logic [11:0] SLOP_RST       = 12'd48;

    localparam int MAX_RES = 4;

    // One result item without its last flag
    typedef struct packed {
        logic [1:0]         event_type;
        logic               which_button;
        logic signed [15:0] cursor_x;
        logic signed [15:0] cursor_y;
        logic [1:0]         pressed_buttons;
    } result_t;

    // All results caused by one item
    typedef struct packed {
        logic                      load;
        logic [2:0]                cnt;
        result_t [MAX_RES-1:0]     res;
    } batch_t;

    function automatic result_t make_res(input logic [1:0] ev, input logic btn,
                                         input logic signed [15:0] cx,
                                         input logic signed [15:0] cy,
                                         input logic [1:0] mask);
        result_t r;
        r.event_type      = ev;
        r.which_button    = btn;
        r.cursor_x        = cx;
        r.cursor_y        = cy;
        r.pressed_buttons = mask;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tpc_if.sv =====
// Channel interfaces of the touch press classifier: input items and result items.
// Depends on nothing.
`default_nettype none

interface tpc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [2:0]         action;
    logic               pen_tool;
    logic               side_button;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        now_ms;

    modport source (output valid, kind, action, pen_tool, side_button, pos_x, pos_y,
                    now_ms, input ready);
    modport sink   (input valid, kind, action, pen_tool, side_button, pos_x, pos_y,
                    now_ms, output ready);
endinterface

interface tpc_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         event_type;
    logic               which_button;
    logic signed [15:0] cursor_x;
    logic signed [15:0] cursor_y;
    logic [1:0]         pressed_buttons;
    logic               last_flag;

    modport source (output valid, event_type, which_button, cursor_x, cursor_y,
                    pressed_buttons, last_flag, input ready);
    modport sink   (input valid, event_type, which_button, cursor_x, cursor_y,
                    pressed_buttons, last_flag, output ready);
endinterface

`default_nettype wire

// ===== hdl/tpc_classifier.sv =====
// Touch state and the decision logic that turns one input item into up to four results.
// Depends on tpc_pkg and tpc_in_if; checks use assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tpc_classifier
    import tpc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [15:0] long_press_ms,
    input  wire logic [11:0] slop_px,
    input  wire logic        batch_free,
    tpc_in_if.sink           in_ch,
    output batch_t           batch
);

    logic               pw_reg, pw_next;
    logic               th_reg, th_next;
    logic               tbr_reg, tbr_next;
    logic [31:0]        press_time_reg, press_time_next;
    logic signed [15:0] press_x_reg, press_x_next;
    logic signed [15:0] press_y_reg, press_y_next;
    logic               side_reg, side_next;
    logic [1:0]         mask_reg, mask_next;
    logic signed [15:0] cur_x_reg, cur_x_next;
    logic signed [15:0] cur_y_reg, cur_y_next;
    logic [2:0]         n_next;
    result_t [MAX_RES-1:0] res_next;

    logic               accept;
    logic [31:0]        elapsed;
    logic signed [16:0] dx, dy;
    logic [16:0]        adx, ady;
    logic               stylus;
    logic               beyond_slop;
    logic               press_left;

    assign in_ch.ready = batch_free;
    assign accept      = in_ch.valid && batch_free;

    // Distances used by the long-press and slop tests
    assign elapsed = in_ch.now_ms - press_time_reg;
    assign dx      = {in_ch.pos_x[15], in_ch.pos_x} - {press_x_reg[15], press_x_reg};
    assign dy      = {in_ch.pos_y[15], in_ch.pos_y} - {press_y_reg[15], press_y_reg};
    assign adx     = dx[16] ? (~dx + 17'd1) : dx;
    assign ady     = dy[16] ? (~dy + 17'd1) : dy;
    assign beyond_slop = (adx > {5'd0, slop_px}) || (ady > {5'd0, slop_px});
    assign stylus  = in_ch.pen_tool && (in_ch.action != ACT_HOVER);

    // Walk the item in order, appending each result as it is decided
    always_comb
    begin
        pw_next         = pw_reg;
        th_next         = th_reg;
        tbr_next        = tbr_reg;
        press_time_next = press_time_reg;
        press_x_next    = press_x_reg;
        press_y_next    = press_y_reg;
        side_next       = side_reg;
        mask_next       = mask_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        n_next          = 3'd0;
        res_next        = '0;
        press_left      = 1'b0;

        case (in_ch.kind)
            KIND_POLL:
            begin
                if (pw_reg && (elapsed >= {16'd0, long_press_ms}))
                begin
                    pw_next   = 1'b0;
                    mask_next = mask_next | 2'b10;
                    tbr_next  = BTN_RIGHT;
                    th_next   = 1'b1;
                    res_next[n_next[1:0]] = make_res(EV_PRESS, BTN_RIGHT, cur_x_next,
                                                     cur_y_next, mask_next);
                    n_next = n_next + 3'd1;
                end
            end
            KIND_MULTI:
            begin
                pw_next = 1'b0;
                if (th_reg)
                begin
                    mask_next = tbr_reg ? (mask_next & 2'b01) : (mask_next & 2'b10);
                    th_next   = 1'b0;
                    res_next[n_next[1:0]] = make_res(EV_RELEASE, tbr_reg, cur_x_next,
                                                     cur_y_next, mask_next);
                    n_next = n_next + 3'd1;
                end
            end
            KIND_SINGLE:
            begin
                // Cursor move always comes first
                cur_x_next = in_ch.pos_x;
                cur_y_next = in_ch.pos_y;
                res_next[n_next[1:0]] = make_res(EV_MOVE, BTN_LEFT, cur_x_next,
                                                 cur_y_next, mask_next);
                n_next = n_next + 3'd1;

                // Side button edge toggles the right button
                if (in_ch.side_button != side_reg)
                begin
                    side_next    = in_ch.side_button;
                    mask_next[1] = in_ch.side_button;
                    res_next[n_next[1:0]] = make_res(in_ch.side_button ? EV_PRESS : EV_RELEASE,
                                                     BTN_RIGHT, cur_x_next, cur_y_next,
                                                     mask_next);
                    n_next = n_next + 3'd1;
                end

                case (in_ch.action)
                    ACT_DOWN:
                    begin
                        if (stylus)
                        begin
                            press_left = 1'b1;
                        end
                        else
                        begin
                            pw_next         = 1'b1;
                            press_time_next = in_ch.now_ms;
                            press_x_next    = in_ch.pos_x;
                            press_y_next    = in_ch.pos_y;
                        end
                    end
                    ACT_MOVE:
                    begin
                        if (pw_reg && beyond_slop)
                        begin
                            pw_next    = 1'b0;
                            press_left = 1'b1;
                        end
                    end
                    ACT_UP:
                    begin
                        pw_next    = 1'b0;
                        press_left = pw_reg;
                    end
                    default:
                    begin
                        pw_next = pw_reg;
                    end
                endcase

                // Left press from stylus tip, drag or tap
                if (press_left)
                begin
                    mask_next = mask_next | 2'b01;
                    tbr_next  = BTN_LEFT;
                    th_next   = 1'b1;
                    res_next[n_next[1:0]] = make_res(EV_PRESS, BTN_LEFT, cur_x_next,
                                                     cur_y_next, mask_next);
                    n_next = n_next + 3'd1;
                end

                // Release on lift of whichever button the touch holds
                if ((in_ch.action == ACT_UP) && th_next)
                begin
                    mask_next = tbr_next ? (mask_next & 2'b01) : (mask_next & 2'b10);
                    th_next   = 1'b0;
                    res_next[n_next[1:0]] = make_res(EV_RELEASE, tbr_next, cur_x_next,
                                                     cur_y_next, mask_next);
                    n_next = n_next + 3'd1;
                end
            end
            default:
            begin
                n_next = 3'd0;
            end
        endcase
    end

    assign batch.load = accept;
    assign batch.cnt  = n_next;
    assign batch.res  = res_next;

    // Commit state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_reg         <= 1'b0;
            th_reg         <= 1'b0;
            tbr_reg        <= BTN_LEFT;
            press_time_reg <= '0;
            press_x_reg    <= '0;
            press_y_reg    <= '0;
            side_reg       <= 1'b0;
            mask_reg       <= '0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
        end
        else if (accept)
        begin
            pw_reg         <= pw_next;
            th_reg         <= th_next;
            tbr_reg        <= tbr_next;
            press_time_reg <= press_time_next;
            press_x_reg    <= press_x_next;
            press_y_reg    <= press_y_next;
            side_reg       <= side_next;
            mask_reg       <= mask_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
        end
    end

    // A held left touch button always shows in the mask
    `TPC_ASSERT_IMP(a_left_held_in_mask, clk, rst_n, th_reg && !tbr_reg, mask_reg[0])
    // Only single-pointer items can produce more than one result
    `TPC_ASSERT_IMP(a_multi_res_single, clk, rst_n, accept && (n_next > 3'd1),
                    in_ch.kind == KIND_SINGLE)

endmodule

`default_nettype wire

// ===== hdl/tpc_emitter.sv =====
// Holds one item's results and hands out one per cycle while out_ch.ready is high.
// Depends on tpc_pkg and tpc_out_if; checks use assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tpc_emitter
    import tpc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire batch_t batch,
    output logic        batch_free,
    tpc_out_if.source   out_ch
);

    result_t [MAX_RES-1:0] res_reg;
    logic [2:0]            cnt_reg;
    logic [1:0]            idx_reg;
    logic                  last;
    logic                  take;

    assign last       = ({1'b0, idx_reg} + 3'd1) == cnt_reg;
    assign take       = out_ch.valid && out_ch.ready;
    assign batch_free = (cnt_reg == 3'd0) || (take && last);

    // Present the current result
    assign out_ch.valid           = cnt_reg != 3'd0;
    assign out_ch.event_type      = res_reg[idx_reg].event_type;
    assign out_ch.which_button    = res_reg[idx_reg].which_button;
    assign out_ch.cursor_x        = res_reg[idx_reg].cursor_x;
    assign out_ch.cursor_y        = res_reg[idx_reg].cursor_y;
    assign out_ch.pressed_buttons = res_reg[idx_reg].pressed_buttons;
    assign out_ch.last_flag       = last;

    // Load a new batch or advance through the current one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (batch.load)
        begin
            cnt_reg <= batch.cnt;
            idx_reg <= '0;
        end
        else if (take)
        begin
            if (last)
            begin
                cnt_reg <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (batch.load)
        begin
            res_reg <= batch.res;
        end
    end

    // Read pointer stays inside the held batch
    `TPC_ASSERT_IMP(a_idx_in_batch, clk, rst_n, cnt_reg != 3'd0,
                    {1'b0, idx_reg} < cnt_reg)
    // A new batch never overwrites results still to be delivered
    `TPC_ASSERT_IMP(a_no_overwrite, clk, rst_n, batch.load,
                    (cnt_reg == 3'd0) || (take && last))
    // After the final result goes out with no new item, the buffer is empty
    `TPC_ASSERT_NXT(a_drain_empty, clk, rst_n, take && last && !batch.load,
                    cnt_reg == 3'd0)

endmodule

`default_nettype wire

// ===== hdl/touch_press_classifier_unit.sv =====
// Top level of the touch press classifier: configuration registers and the two stages.
// Depends on tpc_pkg, tpc_if, tpc_classifier and tpc_emitter.
`default_nettype none

// Each input item is decided in the cycle it is accepted and its results, up to four
// (cursor move, side button, touch press, touch release), are loaded into a result
// buffer that delivers one result per cycle while the receiver is ready, the first in
// the cycle after acceptance. An item is taken in the same cycle the previous item's
// last result is taken, so the result buffer's single output port limits the item
// rate. Poll and multi-pointer items often produce no result. Registers long_press_ms
// (index 0) and slop_px (index 1) reset to 500 and 48 and are to be written only while
// the block is idle; the user is bound to this, the block itself does not enforce it.

module touch_press_classifier_unit
    import tpc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    tpc_in_if.sink           in_ch,
    tpc_out_if.source        out_ch,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [15:0] long_press_reg;
    logic [11:0] slop_reg;
    batch_t      batch;
    logic        batch_free;

    // Decode configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg <= LONG_PRESS_RST;
            slop_reg       <= SLOP_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_LONG_PRESS: long_press_reg <= cfg_data;
                REG_SLOP:       slop_reg       <= cfg_data[11:0];
            endcase
        end
    end

    tpc_classifier u_classifier (
        .clk           (clk),
        .rst_n         (rst_n),
        .long_press_ms (long_press_reg),
        .slop_px       (slop_reg),
        .batch_free    (batch_free),
        .in_ch         (in_ch),
        .batch         (batch)
    );

    tpc_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .batch      (batch),
        .batch_free (batch_free),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tpc_event_board_pkg.sv =====
// Expected-event store for the touch press classifier testbench: item and event types,
// plus a class that tracks the gesture state and checks each result against it.
// Depends on tpc_pkg for the field codes and register reset values.
package tpc_event_board_pkg;
    import tpc_pkg::*;

    // Codes the RTL package does not name
    localparam logic [1:0] KIND_NONE  = 2'd3;
    localparam logic [2:0] ACT_OTHER  = 3'd4;
    localparam logic [2:0] ACT_UNUSED = 3'd7;
    localparam logic [1:0] MASK_LEFT  = 2'b01;
    localparam logic [1:0] MASK_RIGHT = 2'b10;

    typedef struct packed {
        logic [1:0]         kind;
        logic [2:0]         action;
        logic               pen_tool;
        logic               side_button;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [31:0]        now_ms;
    } press_item_t;

    typedef struct packed {
        logic [1:0]         event_type;
        logic               which_button;
        logic signed [15:0] cursor_x;
        logic signed [15:0] cursor_y;
        logic [1:0]         pressed_buttons;
        logic               last_flag;
    } mouse_event_t;

    class mouse_event_board;
        logic [15:0]        long_ms;
        logic [11:0]        slop;
        bit                 waiting;
        bit                 held;
        bit                 held_right;
        bit                 side_on;
        logic [31:0]        press_t;
        logic signed [15:0] press_px;
        logic signed [15:0] press_py;
        logic [1:0]         mask;
        logic signed [15:0] cur_x;
        logic signed [15:0] cur_y;
        mouse_event_t       pending[$];
        mouse_event_t       batch[$];
        int                 errors;
        int                 items;
        int                 checked;

        function new();
            long_ms    = LONG_PRESS_RST;
            slop       = SLOP_RST;
            waiting    = 0;
            held       = 0;
            held_right = 0;
            side_on    = 0;
            press_t    = '0;
            press_px   = '0;
            press_py   = '0;
            mask       = '0;
            cur_x      = '0;
            cur_y      = '0;
            errors     = 0;
            items      = 0;
            checked    = 0;
        endfunction

        function void set_reg(input logic idx, input logic [15:0] val);
            if (idx == REG_LONG_PRESS)
                long_ms = val;
            else
                slop = val[11:0];
        endfunction

        function void push_event(input logic [1:0] ev, input logic btn);
            mouse_event_t e;
            e.event_type      = ev;
            e.which_button    = btn;
            e.cursor_x        = cur_x;
            e.cursor_y        = cur_y;
            e.pressed_buttons = mask;
            e.last_flag       = 1'b0;
            batch.insert(batch.size(), e);
        endfunction

        // Press or release the button owned by the touch logic
        function void touch_button(input bit right, input bit down);
            logic [1:0] bits;
            bits = right ? MASK_RIGHT : MASK_LEFT;
            if (down)
                mask = mask | bits;
            else
                mask = mask & ~bits;
            held_right = right;
            held       = down;
            push_event(down ? EV_PRESS : EV_RELEASE, right ? BTN_RIGHT : BTN_LEFT);
        endfunction

        // Work out the events one accepted item causes and queue them
        function void note_item(input press_item_t it);
            bit          stylus;
            int          dx;
            int          dy;
            logic [31:0] held_for;
            items++;
            batch.delete();
            case (it.kind)
                KIND_POLL:
                begin
                    held_for = it.now_ms - press_t;
                    if (waiting && held_for >= {16'd0, long_ms})
                    begin
                        waiting = 0;
                        touch_button(1'b1, 1'b1);
                    end
                end
                KIND_MULTI:
                begin
                    waiting = 0;
                    if (held)
                        touch_button(held_right, 1'b0);
                end
                KIND_SINGLE:
                begin
                    stylus = it.pen_tool && (it.action != ACT_HOVER);
                    cur_x  = it.pos_x;
                    cur_y  = it.pos_y;
                    push_event(EV_MOVE, BTN_LEFT);
                    // Side button owns mask bit1 alongside a touch right press
                    if (it.side_button != side_on)
                    begin
                        side_on = it.side_button;
                        if (side_on)
                            mask = mask | MASK_RIGHT;
                        else
                            mask = mask & MASK_LEFT;
                        push_event(side_on ? EV_PRESS : EV_RELEASE, BTN_RIGHT);
                    end
                    case (it.action)
                        ACT_DOWN:
                        begin
                            if (stylus)
                                touch_button(1'b0, 1'b1);
                            else
                            begin
                                waiting  = 1;
                                press_t  = it.now_ms;
                                press_px = it.pos_x;
                                press_py = it.pos_y;
                            end
                        end
                        ACT_MOVE:
                        begin
                            dx = int'(it.pos_x) - int'(press_px);
                            dy = int'(it.pos_y) - int'(press_py);
                            if (dx < 0)
                                dx = -dx;
                            if (dy < 0)
                                dy = -dy;
                            if (waiting && (dx > int'(slop) || dy > int'(slop)))
                            begin
                                waiting = 0;
                                touch_button(1'b0, 1'b1);
                            end
                        end
                        ACT_UP:
                        begin
                            if (waiting)
                            begin
                                waiting = 0;
                                touch_button(1'b0, 1'b1);
                            end
                            if (held)
                                touch_button(held_right, 1'b0);
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            if (batch.size() > 0)
                batch[batch.size() - 1].last_flag = 1'b1;
            foreach (batch[i])
                pending.insert(pending.size(), batch[i]);
        endfunction

        function void check_field(input string name, input int want, input int got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Compare one delivered event with the oldest expected one
        function void check_event(input mouse_event_t got);
            mouse_event_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result: event_type %0d at (%0d, %0d)",
                       got.event_type, got.cursor_x, got.cursor_y);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            check_field("event_type", int'(want.event_type), int'(got.event_type));
            check_field("which_button", int'(want.which_button), int'(got.which_button));
            check_field("cursor_x", int'(want.cursor_x), int'(got.cursor_x));
            check_field("cursor_y", int'(want.cursor_y), int'(got.cursor_y));
            check_field("pressed_buttons", int'(want.pressed_buttons),
                        int'(got.pressed_buttons));
            check_field("last_flag", int'(want.last_flag), int'(got.last_flag));
        endfunction
    endclass

endpackage

// ===== tb/sv/testbench.sv =====
// Top of the touch press classifier testbench: clock, reset, channel drivers and checks.
// Depends on tpc_pkg, the tpc_if interfaces, tpc_event_board_pkg and the unit itself.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tpc_pkg::*;
    import tpc_event_board_pkg::*;

    localparam int WATCHDOG  = 2000;
    localparam int LONG_HOLD = 200;
    localparam int SETTLE    = 4;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [15:0] cfg_data;

    tpc_in_if  in_ch();
    tpc_out_if out_ch();

    mouse_event_board board;
    int quiet_cycles = 0;
    int sent         = 0;
    int settings     = 1;
    bit hold_req     = 0;
    bit src_steady   = 0;
    bit sink_steady  = 0;
    bit side_now     = 0;

    touch_press_classifier_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive the result ready: random stalls, long hold-off on request
    initial
    begin
        int stall;
        stall = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                for (int i = 0; i < LONG_HOLD; i++)
                    @(negedge clk);
                out_ch.ready <= 1'b1;
                hold_req = 0;
                stall = 0;
            end
            else
            begin
                if (stall == 0 && !sink_steady && $urandom_range(0, 3) == 0)
                    stall = pick_gap();
                if (stall > 0)
                begin
                    out_ch.ready <= 1'b0;
                    stall--;
                end
                else
                    out_ch.ready <= 1'b1;
            end
        end
    end

    // Note accepted items, check results, watch for a hang
    always @(posedge clk)
    begin
        press_item_t  item;
        mouse_event_t got;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                item.kind        = in_ch.kind;
                item.action      = in_ch.action;
                item.pen_tool    = in_ch.pen_tool;
                item.side_button = in_ch.side_button;
                item.pos_x       = in_ch.pos_x;
                item.pos_y       = in_ch.pos_y;
                item.now_ms      = in_ch.now_ms;
                board.note_item(item);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got.event_type      = out_ch.event_type;
                got.which_button    = out_ch.which_button;
                got.cursor_x        = out_ch.cursor_x;
                got.cursor_y        = out_ch.cursor_y;
                got.pressed_buttons = out_ch.pressed_buttons;
                got.last_flag       = out_ch.last_flag;
                board.check_event(got);
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG)
            begin
                $error("no handshake for %0d cycles, %0d results outstanding",
                       WATCHDOG, board.pending.size());
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // Offer one item after a random gap (none while src_steady) and hold it until taken
    task automatic post(input logic [1:0] k, input logic [2:0] a, input logic st,
                        input logic sb, input logic signed [15:0] x,
                        input logic signed [15:0] y, input logic [31:0] t);
        int gap;
        gap = src_steady ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.kind        <= k;
        in_ch.action      <= a;
        in_ch.pen_tool    <= st;
        in_ch.side_button <= sb;
        in_ch.pos_x       <= x;
        in_ch.pos_y       <= y;
        in_ch.now_ms      <= t;
        in_ch.valid       <= 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sent++;
    endtask

    // Drop valid and hold until every expected result is in
    task automatic wait_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        board.set_reg(idx, val);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // One press from down to lift, hover or other action, with moves, polls, multi-touch
    task automatic gesture();
        logic [31:0]        t;
        logic [31:0]        off;
        logic signed [15:0] x;
        logic signed [15:0] y;
        bit                 stylus;
        int                 lp;
        int                 sl;
        int                 d;
        int                 r;
        lp = int'(board.long_ms);
        sl = int'(board.slop);
        t = $urandom;
        x = 16'($urandom);
        y = 16'($urandom);
        stylus = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 7) == 0)
            side_now = ~side_now;
        post(KIND_SINGLE, ACT_DOWN, stylus, side_now, x, y, t);
        repeat ($urandom_range(0, 4))
        begin
            case ($urandom_range(0, 5))
                0, 1:
                begin
                    r = $urandom_range(0, 3);
                    d = (r == 0) ? sl : (r == 1) ? sl + 1 : $urandom_range(0, sl + 1);
                    if ($urandom_range(0, 1))
                        d = -d;
                    if ($urandom_range(0, 1))
                        x = x + d[15:0];
                    else
                        y = y + d[15:0];
                    t = t + $urandom_range(0, 20);
                    if ($urandom_range(0, 7) == 0)
                        side_now = ~side_now;
                    post(KIND_SINGLE, ACT_MOVE, stylus, side_now, x, y, t);
                end
                2:
                begin
                    x = 16'($urandom);
                    y = 16'($urandom);
                    post(KIND_SINGLE, ACT_MOVE, stylus, side_now, x, y, t);
                end
                3, 4:
                begin
                    case ($urandom_range(0, 2))
                        0: off = lp;
                        1: off = (lp > 0) ? lp - 1 : 0;
                        default: off = $urandom_range(0, 2 * lp + 2);
                    endcase
                    post(KIND_POLL, 3'($urandom), 1'($urandom), 1'($urandom),
                         16'($urandom), 16'($urandom), t + off);
                end
                default:
                    post(KIND_MULTI, 3'($urandom), 1'($urandom), side_now,
                         16'($urandom), 16'($urandom), $urandom);
            endcase
        end
        if ($urandom_range(0, 7) == 0)
            side_now = ~side_now;
        t = t + $urandom_range(0, 2 * lp + 2);
        r = $urandom_range(0, 9);
        if (r == 0)
            post(KIND_SINGLE, ACT_HOVER, 1'($urandom), side_now, x, y, t);
        else if (r == 1)
            post(KIND_SINGLE, 3'($urandom_range(ACT_OTHER, ACT_UNUSED)), stylus, side_now,
                 x, y, t);
        else
            post(KIND_SINGLE, ACT_UP, stylus, side_now, x, y, t);
    endtask

    // Mostly whole gestures, the rest fully random items
    task automatic random_items(input int n);
        int target;
        target = sent + n;
        while (sent < target)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                side_now = 1'($urandom);
                post(2'($urandom), 3'($urandom), 1'($urandom), side_now, 16'($urandom),
                     16'($urandom), $urandom);
            end
            else
                gesture();
        end
    endtask

    task automatic new_setting(input logic [15:0] lp, input logic [15:0] sl);
        wait_drained();
        write_reg(REG_LONG_PRESS, lp);
        write_reg(REG_SLOP, sl);
        settings++;
    endtask

    initial
    begin
        logic [15:0] v;
        board = new();
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = REG_LONG_PRESS;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.kind        = KIND_POLL;
        in_ch.action      = ACT_DOWN;
        in_ch.pen_tool    = 1'b0;
        in_ch.side_button = 1'b0;
        in_ch.pos_x       = '0;
        in_ch.pos_y       = '0;
        in_ch.now_ms      = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Idle poll, multi-touch with nothing held, ignored kind
        post(KIND_POLL, ACT_DOWN, 0, 0, 0, 0, 32'd10);
        post(KIND_MULTI, ACT_MOVE, 0, 0, 0, 0, 32'd20);
        post(KIND_NONE, ACT_DOWN, 1, 1, 16'sh7fff, -16'sd1, 32'hffff_ffff);
        // Long press: too early, then exactly on time, then lift
        post(KIND_SINGLE, ACT_DOWN, 0, 0, 100, 100, 32'd1000);
        post(KIND_POLL, ACT_DOWN, 0, 0, 0, 0, 32'd1499);
        post(KIND_POLL, ACT_DOWN, 0, 0, 0, 0, 32'd1500);
        post(KIND_SINGLE, ACT_UP, 0, 0, 100, 100, 32'd1600);
        // Drag: at the slop edge, then one past it
        post(KIND_SINGLE, ACT_DOWN, 0, 0, 0, 0, 32'd2000);
        post(KIND_SINGLE, ACT_MOVE, 0, 0, 48, -48, 32'd2010);
        post(KIND_SINGLE, ACT_MOVE, 0, 0, 49, 0, 32'd2020);
        post(KIND_SINGLE, ACT_UP, 0, 0, 49, 0, 32'd2030);
        // Tap
        post(KIND_SINGLE, ACT_DOWN, 0, 0, 5, 5, 32'd3000);
        post(KIND_SINGLE, ACT_UP, 0, 0, 5, 5, 32'd3001);
        // Stylus with side button, repeated press, multi-touch release
        post(KIND_SINGLE, ACT_DOWN, 1, 1, 10, 20, 32'd4000);
        post(KIND_SINGLE, ACT_DOWN, 1, 1, 11, 21, 32'd4001);
        post(KIND_MULTI, ACT_MOVE, 0, 1, 0, 0, 32'd4002);
        post(KIND_SINGLE, ACT_UP, 1, 0, 11, 21, 32'd4003);
        // Long press across the time wrap at the most negative corner
        post(KIND_SINGLE, ACT_DOWN, 0, 0, -16'sd32768, -16'sd32768, 32'hffff_ff00);
        post(KIND_POLL, ACT_DOWN, 0, 0, 0, 0, 32'h0000_0100);
        // Hover exit with stylus flag, unused action, side sharing bit1
        post(KIND_SINGLE, ACT_HOVER, 1, 1, 16'sh7fff, 16'sh7fff, 32'd5000);
        post(KIND_SINGLE, ACT_UNUSED, 0, 0, 16'sh7fff, 16'sh7fff, 32'd5001);
        post(KIND_SINGLE, ACT_UP, 0, 0, 16'sh7fff, 16'sh7fff, 32'd5002);
        // Four results from one lift, then a plain other action
        post(KIND_SINGLE, ACT_DOWN, 0, 0, 0, 0, 32'd6000);
        post(KIND_SINGLE, ACT_UP, 0, 1, 0, 0, 32'd6001);
        post(KIND_SINGLE, ACT_OTHER, 0, 0, 0, 0, 32'd6002);
        side_now = 0;
        random_items(40);

        // Long press 1 ms and zero slop; receiver holds off while items keep coming
        new_setting(16'd1, 16'd0);
        src_steady = 1;
        hold_req   = 1;
        random_items(24);
        src_steady = 0;
        random_items(34);

        // Largest values, upper data bits random; sender pauses halfway
        v = 16'($urandom);
        v[11:0] = 12'hfff;
        new_setting(16'hffff, v);
        random_items(28);
        wait_drained();
        random_items(28);

        // Zero long press fires on the first poll; no idling on either side at first
        new_setting(16'd0, 16'd1);
        src_steady  = 1;
        sink_steady = 1;
        random_items(30);
        src_steady  = 0;
        sink_steady = 0;
        random_items(26);

        new_setting(16'($urandom_range(1, 2000)), 16'($urandom_range(0, 300)));
        random_items(55);

        wait_drained();
        repeat (10) @(posedge clk);
        if (board.pending.size() != 0)
        begin
            $error("%0d expected results never arrived", board.pending.size());
            board.errors++;
        end
        $display("summary: %0d items under %0d register settings, %0d results checked",
                 board.items, settings, board.checked);
        $display("summary: taps, drags, long presses, stylus and side button, time wrap");
        if (board.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
